// ----- hdl/fssm_pkg.sv -----
// Shared types, constants and helpers for the fall stage state machine.
`timescale 1ns / 1ps

package fssm_pkg;

  // Indicator mask width on the stream and the number of mask bits that are counted
  localparam int IND_W           = 10;
  localparam int INDICATOR_COUNT = 10;
  localparam int IND_USED        = (INDICATOR_COUNT < IND_W) ? INDICATOR_COUNT : IND_W;
  localparam int CNT_W           = 4;   // holds 0..IND_W

  localparam int TIME_W = 32;
  localparam int CONF_W = 9;
  localparam int MS_W   = 16;
  localparam int FA_W   = 16;
  localparam int CC_W   = 4;

  localparam int IN_DATA_W  = 56;  // 51 payload bits rounded up to bytes
  localparam int OUT_DATA_W = 24;  // 19 payload bits rounded up to bytes

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTER_MIN_IND   = 3'd0,
    REG_ENTER_MIN_CONF  = 3'd1,
    REG_CONFIRM_MIN_IND = 3'd2,
    REG_CONFIRM_MIN_CONF = 3'd3,
    REG_CONFIRMS_NEEDED = 3'd4,
    REG_PREFALL_TIMEOUT = 3'd5,
    REG_RECOVERY        = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STAGE_NORMAL   = 2'd0,
    STAGE_PREFALL  = 2'd1,
    STAGE_DETECTED = 2'd2,
    STAGE_POSTFALL = 2'd3
  } stage_t;

  localparam logic              MODE_EVAL  = 1'b0;
  localparam logic              MODE_CLEAR = 1'b1;

  localparam logic [CNT_W-1:0]  RST_ENTER_MIN_IND    = 4'd2;
  localparam logic [CONF_W-1:0] RST_ENTER_MIN_CONF   = 9'd64;   // 0.25
  localparam logic [CNT_W-1:0]  RST_CONFIRM_MIN_IND  = 4'd4;
  localparam logic [CONF_W-1:0] RST_CONFIRM_MIN_CONF = 9'd128;  // 0.5
  localparam logic [CC_W-1:0]   RST_CONFIRMS_NEEDED  = 4'd1;
  localparam logic [MS_W-1:0]   RST_PREFALL_TIMEOUT  = 16'd2000;
  localparam logic [MS_W-1:0]   RST_RECOVERY         = 16'd8000;

  localparam logic [CC_W-1:0]   CC_MAX = {CC_W{1'b1}};
  localparam logic [FA_W-1:0]   FA_MAX = {FA_W{1'b1}};

  function automatic logic [CNT_W-1:0] count_active(input logic [IND_W-1:0] bits);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < IND_USED; i++) begin
      n = n + CNT_W'(bits[i]);
    end
    return n;
  endfunction

endpackage

// ----- hdl/fall_stage_state_machine.sv -----
// Fall stage state machine: input register, stage update, output register.
`timescale 1ns / 1ps

// Channel | Ports                          | Fields (lowest bit up)
// in      | in_tvalid/in_tready/in_tdata   | tdata: time_ms, indicators, impact_confidence
//         | in_tuser                       | tuser: mode
// out     | out_tvalid/out_tready/out_tdata| tdata: fall_now, stage, false_alarms
// cfg     | cfg_wr_en/cfg_index/cfg_wdata  | one register per write, no read-back
//
// One transaction per cycle sustained while out_tready stays high; the result passes
// through the input register and then the output register before out_tvalid rises.
// The stage, start time and counters update in the same cycle that makes the result.
// Reset (rst_n low, synchronous) clears stage and counters and loads register defaults.
// A stalled output holds its data; the input register still takes a transaction
// while the output register waits, then stalls until the output drains.

module fall_stage_state_machine
  import fssm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // time_ms[31:0], indicators[41:32],
                                            // impact_confidence[50:42], zero pad
  input  logic                  in_tuser,   // mode

  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // fall_now[0], stage[2:1],
                                            // false_alarms[18:3], zero pad

  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [CNT_W-1:0]  enter_min_ind_r;
  logic [CONF_W-1:0] enter_min_conf_r;
  logic [CNT_W-1:0]  confirm_min_ind_r;
  logic [CONF_W-1:0] confirm_min_conf_r;
  logic [CC_W-1:0]   confirms_needed_r;
  logic [MS_W-1:0]   prefall_timeout_r;
  logic [MS_W-1:0]   recovery_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enter_min_ind_r    <= RST_ENTER_MIN_IND;
      enter_min_conf_r   <= RST_ENTER_MIN_CONF;
      confirm_min_ind_r  <= RST_CONFIRM_MIN_IND;
      confirm_min_conf_r <= RST_CONFIRM_MIN_CONF;
      confirms_needed_r  <= RST_CONFIRMS_NEEDED;
      prefall_timeout_r  <= RST_PREFALL_TIMEOUT;
      recovery_r         <= RST_RECOVERY;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ENTER_MIN_IND:    enter_min_ind_r    <= cfg_wdata[CNT_W-1:0];
        REG_ENTER_MIN_CONF:   enter_min_conf_r   <= cfg_wdata[CONF_W-1:0];
        REG_CONFIRM_MIN_IND:  confirm_min_ind_r  <= cfg_wdata[CNT_W-1:0];
        REG_CONFIRM_MIN_CONF: confirm_min_conf_r <= cfg_wdata[CONF_W-1:0];
        REG_CONFIRMS_NEEDED:  confirms_needed_r  <= cfg_wdata[CC_W-1:0];
        REG_PREFALL_TIMEOUT:  prefall_timeout_r  <= cfg_wdata[MS_W-1:0];
        REG_RECOVERY:         recovery_r         <= cfg_wdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic              in_valid_r;
  logic              mode_r;
  logic [TIME_W-1:0] time_r;
  logic [IND_W-1:0]  ind_r;
  logic [CONF_W-1:0] conf_r;

  logic out_valid_r;
  logic advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      mode_r <= in_tuser;
      time_r <= in_tdata[TIME_W-1:0];
      ind_r  <= in_tdata[TIME_W +: IND_W];
      conf_r <= in_tdata[TIME_W+IND_W +: CONF_W];
    end
  end

  // Stage state
  stage_t            stage_r, stage_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic [CC_W-1:0]   confirm_cnt_r, confirm_cnt_nxt;
  logic [FA_W-1:0]   false_alarm_r, false_alarm_nxt;
  logic              fall_nxt;

  logic [CNT_W-1:0]  active;
  logic              enter_ok;
  logic              confirm_ok;
  logic [CC_W-1:0]   cnt_inc;
  logic [TIME_W-1:0] elapsed;
  logic              prefall_expired;
  logic              recovery_done;

  always_comb begin
    active          = count_active(ind_r);
    enter_ok        = (active >= enter_min_ind_r) && (conf_r > enter_min_conf_r);
    confirm_ok      = (active >= confirm_min_ind_r) && (conf_r > confirm_min_conf_r);
    cnt_inc         = (confirm_cnt_r == CC_MAX) ? CC_MAX : confirm_cnt_r + 1'b1;
    elapsed         = time_r - start_r;  // wraps mod 2^32
    prefall_expired = elapsed > TIME_W'(prefall_timeout_r);
    recovery_done   = elapsed > TIME_W'(recovery_r);
  end

  // Next stage
  always_comb begin
    stage_nxt = stage_r;
    if (mode_r == MODE_CLEAR) begin
      stage_nxt = STAGE_NORMAL;
    end else begin
      unique case (stage_r)
        STAGE_NORMAL: begin
          if (enter_ok) stage_nxt = STAGE_PREFALL;
        end
        STAGE_PREFALL: begin
          priority if (confirm_ok) begin
            if (cnt_inc >= confirms_needed_r) stage_nxt = STAGE_DETECTED;
          end else if (prefall_expired) begin
            stage_nxt = STAGE_NORMAL;
          end else begin
            stage_nxt = stage_r;
          end
        end
        STAGE_DETECTED: stage_nxt = STAGE_POSTFALL;
        STAGE_POSTFALL: begin
          if (recovery_done) stage_nxt = STAGE_NORMAL;
        end
        default: stage_nxt = STAGE_NORMAL;
      endcase
    end
  end

  // Counters, start time and fall pulse
  always_comb begin
    start_nxt       = start_r;
    confirm_cnt_nxt = confirm_cnt_r;
    false_alarm_nxt = false_alarm_r;
    fall_nxt        = 1'b0;
    if (mode_r == MODE_CLEAR) begin
      start_nxt       = '0;
      confirm_cnt_nxt = '0;
    end else begin
      unique case (stage_r)
        STAGE_NORMAL: begin
          if (enter_ok) begin
            start_nxt       = time_r;
            confirm_cnt_nxt = '0;
          end
        end
        STAGE_PREFALL: begin
          priority if (confirm_ok) begin
            confirm_cnt_nxt = cnt_inc;
            fall_nxt        = (cnt_inc >= confirms_needed_r);
          end else if (prefall_expired) begin
            if (false_alarm_r != FA_MAX) false_alarm_nxt = false_alarm_r + 1'b1;
          end else begin
            false_alarm_nxt = false_alarm_r;
          end
        end
        STAGE_DETECTED: start_nxt = time_r;
        STAGE_POSTFALL: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r       <= STAGE_NORMAL;
      start_r       <= '0;
      confirm_cnt_r <= '0;
      false_alarm_r <= '0;
    end else if (advance) begin
      stage_r       <= stage_nxt;
      start_r       <= start_nxt;
      confirm_cnt_r <= confirm_cnt_nxt;
      false_alarm_r <= false_alarm_nxt;
    end
  end

  // Output register
  logic         fall_out_r;
  stage_t       stage_out_r;
  logic [FA_W-1:0] fa_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fall_out_r  <= fall_nxt;
      stage_out_r <= stage_nxt;
      fa_out_r    <= false_alarm_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-FA_W-3){1'b0}}, fa_out_r, stage_out_r, fall_out_r};

  // A fall pulse is only ever reported together with the detected stage
  a_fall_in_detected: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[2:1] == STAGE_DETECTED)
    else $error("fall pulse without detected stage");

  // Detected always moves on to post-fall with the next evaluated transaction
  a_detected_to_post: assert property (@(posedge clk) disable iff (!rst_n)
    advance && stage_r == STAGE_DETECTED && mode_r == MODE_EVAL
    |=> stage_r == STAGE_POSTFALL)
    else $error("detected stage did not move to post-fall");

  // False alarm count never goes down outside reset
  a_fa_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> false_alarm_r >= $past(false_alarm_r))
    else $error("false alarm count decreased");

  // Output holds a result whenever the state advanced in the previous cycle
  a_adv_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result lost after state update");

endmodule
